>>> hdl/tshfe_pkg.sv
// shared types, phase codes and record layout of the server hello extractor
`default_nettype none

package tshfe_pkg;

  typedef enum logic [3:0] {
    PH_VERSION  = 4'd0,
    PH_RANDOM   = 4'd1,
    PH_SID_LEN  = 4'd2,
    PH_SID      = 4'd3,
    PH_CIPHER   = 4'd4,
    PH_COMP     = 4'd5,
    PH_EXT_LEN  = 4'd6,
    PH_EXT_HDR  = 4'd7,
    PH_EXT_BODY = 4'd8,
    PH_SKIP     = 4'd9,
    PH_DONE     = 4'd10,
    PH_ERROR    = 4'd11
  } phase_t;

  localparam logic [15:0] EXT_ALPN   = 16'h0010;
  localparam logic [15:0] EXT_SUPVER = 16'h002b;
  localparam logic [7:0]  RANDOM_LEN = 8'd32;
  localparam logic [7:0]  ALPN_NONE  = 8'h30;

  localparam logic REC_ENTRY   = 1'b0;
  localparam logic REC_SUMMARY = 1'b1;

  typedef struct packed {
    logic        record_kind;
    logic [15:0] extension_type;
    logic [15:0] tls_version;
    logic [15:0] cipher_suite;
    logic [7:0]  alpn_first_char;
    logic [7:0]  alpn_last_char;
    logic        alpn_present;
    logic [6:0]  listed_count;
    logic        parse_status;
    logic        quic_flag;
    logic        last_record;
  } record_t;

  // up to two records per input byte: an extension entry, then the summary
  typedef struct packed {
    logic    ent_valid;
    logic    sum_valid;
    record_t ent;
    record_t sum;
  } push_t;

  function automatic logic is_grease(input logic [15:0] v);
    return ((v & 16'h0f0f) == 16'h0a0a) && (v[15:8] == v[7:0]);
  endfunction

endpackage

`default_nettype wire

>>> hdl/tshfe_parser.sv
// byte-wise parse state and record generation for one server hello body
`default_nettype none

module tshfe_parser #(
  parameter int LIST_BYTES = 512,
  parameter int MAX_LISTED = 99
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire logic [7:0]       data_byte,
  input  wire logic             end_of_body,
  input  wire logic             is_quic,
  output tshfe_pkg::push_t      push
);

  localparam logic [12:0] LIST_LIM = 13'(LIST_BYTES);
  localparam logic [6:0]  LIST_CAP = 7'(MAX_LISTED);

  tshfe_pkg::phase_t parse_phase, parse_phase_next;
  logic [7:0]  field_counter, field_counter_next;
  logic [15:0] block_remaining, block_remaining_next;
  logic [15:0] current_ext_type, current_ext_type_next;
  logic [15:0] current_ext_len, current_ext_len_next;
  logic [15:0] ext_left, ext_left_next;
  logic [7:0]  alpn_name_len, alpn_name_len_next;
  logic [15:0] version_reg, version_reg_next;
  logic [15:0] cipher_reg, cipher_reg_next;
  logic [15:0] alpn_chars, alpn_chars_next;
  logic        alpn_seen, alpn_seen_next;
  logic [6:0]  listed_reg, listed_reg_next;
  logic        error_flag, error_flag_next;

  logic [15:0] br_dec;
  logic [15:0] ext_off;
  logic [15:0] sv_value;
  logic [12:0] list_pos;
  logic        may_list;
  logic        alpn_ok;
  logic        sum_ok;
  logic        ent_hit;

  function automatic tshfe_pkg::phase_t next_in_block(input logic [15:0] rem);
    if (rem == 16'd0) begin
      return tshfe_pkg::PH_DONE;
    end else if (rem >= 16'd4) begin
      return tshfe_pkg::PH_EXT_HDR;
    end else begin
      return tshfe_pkg::PH_SKIP;
    end
  endfunction

  // rendered list: four hex digits per type plus comma, five spare characters
  assign list_pos = ({6'd0, listed_reg} << 2) + {6'd0, listed_reg} + 13'd4;
  assign may_list = (listed_reg < LIST_CAP) &&
                    ((listed_reg == 7'd0) ? (13'd5 <= LIST_LIM) : (list_pos <= LIST_LIM));

  assign br_dec   = block_remaining - 16'd1;
  assign ext_off  = current_ext_len - ext_left;
  assign sv_value = {field_counter, data_byte};
  assign alpn_ok  = (alpn_name_len != 8'd0) &&
                    (({8'd0, alpn_name_len} + 16'd3) <= current_ext_len);

  always_comb begin
    parse_phase_next      = parse_phase;
    field_counter_next    = field_counter;
    block_remaining_next  = block_remaining;
    current_ext_type_next = current_ext_type;
    current_ext_len_next  = current_ext_len;
    ext_left_next         = ext_left;
    alpn_name_len_next    = alpn_name_len;
    version_reg_next      = version_reg;
    cipher_reg_next       = cipher_reg;
    alpn_chars_next       = alpn_chars;
    alpn_seen_next        = alpn_seen;
    listed_reg_next       = listed_reg;
    error_flag_next       = error_flag;
    ent_hit               = 1'b0;

    case (parse_phase)
      tshfe_pkg::PH_VERSION: begin
        version_reg_next = {version_reg[7:0], data_byte};
        if (field_counter == 8'd1) begin
          field_counter_next = 8'd0;
          parse_phase_next   = tshfe_pkg::PH_RANDOM;
        end else begin
          field_counter_next = field_counter + 8'd1;
        end
      end
      tshfe_pkg::PH_RANDOM: begin
        if (field_counter == tshfe_pkg::RANDOM_LEN - 8'd1) begin
          field_counter_next = 8'd0;
          parse_phase_next   = tshfe_pkg::PH_SID_LEN;
        end else begin
          field_counter_next = field_counter + 8'd1;
        end
      end
      tshfe_pkg::PH_SID_LEN: begin
        block_remaining_next = {8'd0, data_byte};
        parse_phase_next = (data_byte == 8'd0) ? tshfe_pkg::PH_CIPHER : tshfe_pkg::PH_SID;
      end
      tshfe_pkg::PH_SID: begin
        block_remaining_next = br_dec;
        if (br_dec == 16'd0) begin
          parse_phase_next = tshfe_pkg::PH_CIPHER;
        end
      end
      tshfe_pkg::PH_CIPHER: begin
        cipher_reg_next = {cipher_reg[7:0], data_byte};
        if (field_counter == 8'd1) begin
          field_counter_next = 8'd0;
          parse_phase_next   = tshfe_pkg::PH_COMP;
        end else begin
          field_counter_next = field_counter + 8'd1;
        end
      end
      tshfe_pkg::PH_COMP: begin
        parse_phase_next   = tshfe_pkg::PH_EXT_LEN;
        field_counter_next = 8'd0;
      end
      tshfe_pkg::PH_EXT_LEN: begin
        block_remaining_next = {block_remaining[7:0], data_byte};
        if (field_counter == 8'd1) begin
          field_counter_next = 8'd0;
          parse_phase_next   = next_in_block({block_remaining[7:0], data_byte});
        end else begin
          field_counter_next = field_counter + 8'd1;
        end
      end
      tshfe_pkg::PH_EXT_HDR: begin
        if (field_counter < 8'd2) begin
          current_ext_type_next = {current_ext_type[7:0], data_byte};
        end else begin
          current_ext_len_next = {current_ext_len[7:0], data_byte};
        end
        block_remaining_next = br_dec;
        if (field_counter == 8'd3) begin
          field_counter_next = 8'd0;
          if (current_ext_len_next > br_dec) begin
            error_flag_next  = 1'b1;
            parse_phase_next = tshfe_pkg::PH_ERROR;
          end else begin
            if (may_list) begin
              ent_hit         = 1'b1;
              listed_reg_next = listed_reg + 7'd1;
            end
            alpn_name_len_next = 8'd0;
            ext_left_next      = current_ext_len_next;
            if (current_ext_len_next == 16'd0) begin
              parse_phase_next = next_in_block(br_dec);
            end else begin
              parse_phase_next = tshfe_pkg::PH_EXT_BODY;
            end
          end
        end else begin
          field_counter_next = field_counter + 8'd1;
        end
      end
      tshfe_pkg::PH_EXT_BODY: begin
        if (current_ext_type == tshfe_pkg::EXT_ALPN && current_ext_len >= 16'd3) begin
          if (ext_off == 16'd2) begin
            alpn_name_len_next = data_byte;
          end else if (ext_off > 16'd2 && alpn_ok) begin
            // a one-character name sets both characters on the same byte
            if (ext_off == 16'd3) begin
              alpn_chars_next[15:8] = data_byte;
            end
            if (ext_off == {8'd0, alpn_name_len} + 16'd2) begin
              alpn_chars_next[7:0] = data_byte;
              alpn_seen_next       = 1'b1;
            end
          end
        end else if (current_ext_type == tshfe_pkg::EXT_SUPVER &&
                     current_ext_len >= 16'd2) begin
          if (ext_off == 16'd0) begin
            field_counter_next = data_byte;
          end else if (ext_off == 16'd1) begin
            if (!tshfe_pkg::is_grease(sv_value)) begin
              version_reg_next = sv_value;
            end
          end
        end
        ext_left_next        = ext_left - 16'd1;
        block_remaining_next = br_dec;
        if (ext_left == 16'd1) begin
          field_counter_next = 8'd0;
          parse_phase_next   = next_in_block(br_dec);
        end
      end
      tshfe_pkg::PH_SKIP: begin
        block_remaining_next = br_dec;
        if (br_dec == 16'd0) begin
          parse_phase_next = tshfe_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  assign sum_ok = !error_flag_next && (parse_phase_next == tshfe_pkg::PH_DONE ||
                                       parse_phase_next == tshfe_pkg::PH_EXT_LEN);

  always_comb begin
    push.ent_valid = fire && ent_hit;
    push.sum_valid = fire && end_of_body;

    push.ent                = '0;
    push.ent.record_kind    = tshfe_pkg::REC_ENTRY;
    push.ent.extension_type = current_ext_type_next;

    push.sum                 = '0;
    push.sum.record_kind     = tshfe_pkg::REC_SUMMARY;
    push.sum.tls_version     = sum_ok ? version_reg_next : 16'd0;
    push.sum.cipher_suite    = sum_ok ? cipher_reg_next : 16'd0;
    push.sum.alpn_first_char = sum_ok ? alpn_chars_next[15:8] : tshfe_pkg::ALPN_NONE;
    push.sum.alpn_last_char  = sum_ok ? alpn_chars_next[7:0] : tshfe_pkg::ALPN_NONE;
    push.sum.alpn_present    = sum_ok && alpn_seen_next;
    push.sum.listed_count    = sum_ok ? listed_reg_next : 7'd0;
    push.sum.parse_status    = !sum_ok;
    push.sum.quic_flag       = is_quic;
    push.sum.last_record     = 1'b1;
  end

  // the final byte of a body puts the parser back to its start state
  always_ff @(posedge clk) begin
    if (rst || (fire && end_of_body)) begin
      parse_phase      <= tshfe_pkg::PH_VERSION;
      field_counter    <= 8'd0;
      block_remaining  <= 16'd0;
      current_ext_type <= 16'd0;
      current_ext_len  <= 16'd0;
      ext_left         <= 16'd0;
      alpn_name_len    <= 8'd0;
      version_reg      <= 16'd0;
      cipher_reg       <= 16'd0;
      alpn_chars       <= {tshfe_pkg::ALPN_NONE, tshfe_pkg::ALPN_NONE};
      alpn_seen        <= 1'b0;
      listed_reg       <= 7'd0;
      error_flag       <= 1'b0;
    end else if (fire) begin
      parse_phase      <= parse_phase_next;
      field_counter    <= field_counter_next;
      block_remaining  <= block_remaining_next;
      current_ext_type <= current_ext_type_next;
      current_ext_len  <= current_ext_len_next;
      ext_left         <= ext_left_next;
      alpn_name_len    <= alpn_name_len_next;
      version_reg      <= version_reg_next;
      cipher_reg       <= cipher_reg_next;
      alpn_chars       <= alpn_chars_next;
      alpn_seen        <= alpn_seen_next;
      listed_reg       <= listed_reg_next;
      error_flag       <= error_flag_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tshfe_outq.sv
// four-entry result queue taking up to two records per cycle
`default_nettype none

module tshfe_outq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tshfe_pkg::push_t   push,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output tshfe_pkg::record_t      head,
  output logic                    full
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  tshfe_pkg::record_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, wr_ptr_next;
  logic [PW-1:0] rd_ptr, rd_ptr_next;
  logic [PW:0]   count, count_next;
  logic          pop;
  logic [PW-1:0] sum_addr;

  assign out_valid = (count != '0);
  assign head      = mem[rd_ptr];
  // room must exist for an entry and a summary from the same byte
  assign full      = (count > (PW+1)'(DEPTH - 2));
  assign pop       = out_valid && !out_stall;
  assign sum_addr  = push.ent_valid ? wr_ptr + PW'(1) : wr_ptr;

  always_comb begin
    wr_ptr_next = wr_ptr + PW'(push.ent_valid) + PW'(push.sum_valid);
    rd_ptr_next = rd_ptr + PW'(pop);
    count_next  = count + (PW+1)'(push.ent_valid) + (PW+1)'(push.sum_valid)
                  - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.ent_valid) begin
      mem[wr_ptr] <= push.ent;
    end
    if (push.sum_valid) begin
      mem[sum_addr] <= push.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tls_server_hello_field_extractor.sv
// top level of the server hello field extractor
//
//  channel | signals                                        | transaction
//  --------+------------------------------------------------+-------------------------------
//  in      | in_valid, in_stall, data_byte, end_of_body,    | one body byte
//          | is_quic                                        |
//  out     | out_valid, out_stall, record_kind ... last_rec | extension entry or summary
//
// one byte is taken every cycle while in_stall is low; its records sit in a four-entry queue
// from the next cycle; a byte yields at most an entry and a summary, so in_stall rises while
// fewer than two slots are free; the queue drains one record per cycle while out_stall is low
// rst clears the parser state and empties the queue; the final byte restarts the parser
`default_nettype none

module tls_server_hello_field_extractor #(
  parameter int LIST_BYTES = 512,
  parameter int MAX_LISTED = 99
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_body,
  input  wire logic        is_quic,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             record_kind,
  output logic [15:0]      extension_type,
  output logic [15:0]      tls_version,
  output logic [15:0]      cipher_suite,
  output logic [7:0]       alpn_first_char,
  output logic [7:0]       alpn_last_char,
  output logic             alpn_present,
  output logic [6:0]       listed_count,
  output logic             parse_status,
  output logic             quic_flag,
  output logic             last_record
);

  tshfe_pkg::push_t   push;
  tshfe_pkg::record_t head;
  logic               q_full;
  logic               fire;

  assign in_stall = q_full;
  assign fire     = in_valid && !q_full;

  tshfe_parser #(
    .LIST_BYTES (LIST_BYTES),
    .MAX_LISTED (MAX_LISTED)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .data_byte   (data_byte),
    .end_of_body (end_of_body),
    .is_quic     (is_quic),
    .push        (push)
  );

  tshfe_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .full      (q_full)
  );

  assign record_kind     = head.record_kind;
  assign extension_type  = head.extension_type;
  assign tls_version     = head.tls_version;
  assign cipher_suite    = head.cipher_suite;
  assign alpn_first_char = head.alpn_first_char;
  assign alpn_last_char  = head.alpn_last_char;
  assign alpn_present    = head.alpn_present;
  assign listed_count    = head.listed_count;
  assign parse_status    = head.parse_status;
  assign quic_flag       = head.quic_flag;
  assign last_record     = head.last_record;

endmodule

`default_nettype wire
